@@ sv/ffba_pkg.sv @@
package ffba_pkg;

    localparam int unsigned ADDR_W         = 7;
    localparam int unsigned BYTES_W        = 10;
    localparam int unsigned BYTES_PER_WORD = 4;
    localparam int unsigned WORD_SHIFT     = 2;
    localparam int unsigned WORDS_W        = 9;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_FREE    = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [BYTES_W-1:0] alloc_bytes;
        logic [ADDR_W-1:0]  block_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic              status;
    } t_rsp;

    // bytes rounded up to whole words
    function automatic logic [WORDS_W-1:0] bytes_to_words(input logic [BYTES_W-1:0] bytes);
        logic [BYTES_W:0] sum;
        sum = {1'b0, bytes} + (BYTES_W+1)'(BYTES_PER_WORD - 1);
        return WORDS_W'(sum >> WORD_SHIFT);
    endfunction

endpackage

@@ sv/ffba_hdr_mem.sv @@
module ffba_hdr_mem #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ffba_ctrl.sv @@
module ffba_ctrl
    import ffba_pkg::*;
#(
    parameter int unsigned HEAP_WORDS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  t_req                          i_req,
    output logic                          o_done,
    output t_rsp                          o_rsp,
    output logic                          o_mem_we,
    output logic [$clog2(HEAP_WORDS)-1:0] o_mem_waddr,
    output logic [$clog2(HEAP_WORDS):0]   o_mem_wdata,
    output logic [$clog2(HEAP_WORDS)-1:0] o_mem_raddr,
    input  logic [$clog2(HEAP_WORDS):0]   i_mem_rdata
);

    localparam int unsigned AW = $clog2(HEAP_WORDS);
    localparam int unsigned PW = AW + 1;
    localparam int unsigned HW = AW + 1;
    localparam int unsigned CW = ((AW > WORDS_W) ? AW : WORDS_W) + 1;
    localparam int unsigned EW = (PW > ADDR_W) ? PW : ADDR_W;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_SPLIT  = 3'd3;
    localparam logic [2:0] S_FMERGE = 3'd4;

    logic [2:0]         r_state,    n_state;
    logic               r_cmd,      n_cmd;
    logic [WORDS_W-1:0] r_words,    n_words;
    logic [ADDR_W-1:0]  r_addr,     n_addr;
    logic [PW-1:0]      r_at,       n_at;
    logic [AW-1:0]      r_prev,     n_prev;
    logic [HW-1:0]      r_prev_hdr, n_prev_hdr;
    logic [AW-1:0]      r_size,     n_size;
    logic               r_nx_ok,    n_nx_ok;
    logic               r_done,     n_done;
    t_rsp               r_rsp,      n_rsp;

    logic          h_free;
    logic [AW-1:0] h_size;
    logic [PW-1:0] at_pay;
    logic [PW-1:0] next_at;
    logic          at_end;
    logic          fits;
    logic          hit;
    logic [AW-1:0] rest;
    logic [AW-1:0] split_at;
    logic [AW-1:0] merged;
    logic          prev_free;
    logic [AW-1:0] prev_size;

    assign h_free    = i_mem_rdata[AW];
    assign h_size    = i_mem_rdata[AW-1:0];
    assign at_pay    = r_at + PW'(1);
    assign next_at   = at_pay + PW'(h_size);
    assign at_end    = next_at >= PW'(HEAP_WORDS);
    assign fits      = h_free && (CW'(h_size) > (CW'(r_words) + CW'(1)));
    assign hit       = EW'(at_pay) == EW'(r_addr);
    assign rest      = AW'(CW'(h_size) - CW'(r_words) - CW'(1));
    assign split_at  = AW'(at_pay + PW'(r_words));
    assign merged    = (r_nx_ok && h_free) ? (r_size + h_size + AW'(1)) : r_size;
    assign prev_free = r_prev_hdr[AW];
    assign prev_size = r_prev_hdr[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_words     = r_words;
        n_addr      = r_addr;
        n_at        = r_at;
        n_prev      = r_prev;
        n_prev_hdr  = r_prev_hdr;
        n_size      = r_size;
        n_nx_ok     = r_nx_ok;
        n_done      = 1'b0;
        n_rsp       = r_rsp;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_raddr = '0;

        case (r_state)
            S_INIT: begin
                // header 0 spans the whole heap
                o_mem_we    = 1'b1;
                o_mem_wdata = {1'b1, AW'(HEAP_WORDS - 1)};
                n_state     = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_req.cmd;
                    n_words = bytes_to_words(i_req.alloc_bytes);
                    n_addr  = i_req.block_address;
                    n_at    = '0;
                    n_prev  = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_mem_raddr = next_at[AW-1:0];
                if (r_cmd == CMD_ALLOC) begin
                    if (fits) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_at[AW-1:0];
                        o_mem_wdata = {1'b0, AW'(r_words)};
                        n_size      = rest;
                        n_rsp       = '{result_address: ADDR_W'(at_pay), status: STATUS_OK};
                        n_state     = S_SPLIT;
                    end else if (at_end) begin
                        n_rsp   = '{result_address: '0, status: STATUS_FAIL};
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_at = next_at;
                    end
                end else begin
                    if (hit) begin
                        if (h_free) begin
                            // double free
                            n_rsp   = '{result_address: '0, status: STATUS_FAIL};
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_size  = h_size;
                            n_nx_ok = !at_end;
                            n_state = S_FMERGE;
                        end
                    end else if (at_end) begin
                        n_rsp   = '{result_address: '0, status: STATUS_FAIL};
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_prev     = r_at[AW-1:0];
                        n_prev_hdr = i_mem_rdata;
                        n_at       = next_at;
                    end
                end
            end
            S_SPLIT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = split_at;
                o_mem_wdata = {1'b1, r_size};
                n_done      = 1'b1;
                n_state     = S_IDLE;
            end
            S_FMERGE: begin
                // successor header arrives now; predecessor was kept from the walk
                o_mem_we = 1'b1;
                if ((r_at != '0) && prev_free) begin
                    o_mem_waddr = r_prev;
                    o_mem_wdata = {1'b1, prev_size + merged + AW'(1)};
                end else begin
                    o_mem_waddr = r_at[AW-1:0];
                    o_mem_wdata = {1'b1, merged};
                end
                n_rsp   = '{result_address: '0, status: STATUS_OK};
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cmd      <= n_cmd;
        r_words    <= n_words;
        r_addr     <= n_addr;
        r_at       <= n_at;
        r_prev     <= n_prev;
        r_prev_hdr <= n_prev_hdr;
        r_size     <= n_size;
        r_nx_ok    <= n_nx_ok;
        r_rsp      <= n_rsp;
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

@@ sv/first_fit_block_allocator.sv @@
// Throughput: one request at a time; the next start is taken in the cycle
//   o_done pulses. The header chain walk, one memory read a cycle, sets it.
// Reset: synchronous, active low; after reset the block writes header 0 in S_INIT (busy high).
// Results cannot be stalled: o_done is a one-cycle strobe.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int unsigned HEAP_WORDS = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int unsigned AW = $clog2(HEAP_WORDS);

    // header word: {free, size in words}
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [AW:0]   mem_rdata;

    // walker: follows next = at + 1 + size, one header per beat of the read port
    ffba_ctrl #(
        .HEAP_WORDS(HEAP_WORDS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .o_mem_we   (mem_we),
        .o_mem_waddr(mem_waddr),
        .o_mem_wdata(mem_wdata),
        .o_mem_raddr(mem_raddr),
        .i_mem_rdata(mem_rdata)
    );

    // header store, registered read; words inside blocks are never read
    ffba_hdr_mem #(
        .DEPTH(HEAP_WORDS),
        .WIDTH(AW + 1)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

endmodule

@@ sv/ffba_checker.sv @@
module ffba_checker
    import ffba_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_req i_req,
    input logic o_done,
    input t_rsp o_rsp
);

    // header init cycle follows reset
    a_busy_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back results");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == STATUS_FAIL)) |-> (o_rsp.result_address == '0))
        else $error("failed result carries an address");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .i_req  (i_req),
    .o_done (o_done),
    .o_rsp  (o_rsp)
);

@@ test/tb_first_fit_block_allocator.sv @@
module tb_first_fit_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import ffba_pkg::*;

    localparam int unsigned HEAP_WORDS   = 128;
    // Nothing accepted for this long means the block is hung. The slowest
    // legal beat is a full chain walk plus the longest sender gap.
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned FREED_KEEP   = 16;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    first_fit_block_allocator #(
        .HEAP_WORDS(HEAP_WORDS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Shadow heap: one header per word, size in words plus free mark.
    // Only entries reached by the chain walk are ever read.
    // ---------------------------------------------------------------
    logic [7:0] hdr_size [HEAP_WORDS];
    bit         hdr_free [HEAP_WORDS];

    t_rsp rsp_expected_q[$];

    // addresses handed out and not yet returned, and recently returned ones
    logic [ADDR_W-1:0] live_q[$];
    logic [ADDR_W-1:0] freed_q[$];

    int unsigned mismatch_cnt = 0;
    int unsigned fail_cnt     = 0;
    int unsigned stall_cycles = 0;
    bit          start_held   = 1'b0;
    bit          no_gaps      = 1'b0;

    // Walks the shadow chain exactly as the block should, updates the
    // shadow headers and returns the response for this request.
    function automatic t_rsp heap_predict(input t_req r);
        int unsigned at;
        int unsigned prev;
        int unsigned words;
        int unsigned nx;
        bit          found;
        t_rsp        rsp;
        at    = 0;
        prev  = 0;
        found = 1'b0;
        rsp.result_address = '0;
        rsp.status         = STATUS_FAIL;
        if (r.cmd == CMD_ALLOC) begin
            words = (32'(r.alloc_bytes) + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
            while (at < HEAP_WORDS && !found) begin
                // strictly greater: the split always leaves a free remainder
                if (hdr_free[at] && 32'(hdr_size[at]) > words + 1) begin
                    nx = at + 1 + words;
                    if (nx < HEAP_WORDS) begin
                        hdr_free[nx] = 1'b1;
                        hdr_size[nx] = 8'(32'(hdr_size[at]) - words - 1);
                    end
                    hdr_free[at] = 1'b0;
                    hdr_size[at] = 8'(words);
                    rsp.result_address = ADDR_W'(at + 1);
                    rsp.status         = STATUS_OK;
                    found              = 1'b1;
                end else begin
                    at = at + 1 + 32'(hdr_size[at]);
                end
            end
        end else begin
            while (at < HEAP_WORDS && !found) begin
                if (at + 1 == 32'(r.block_address)) begin
                    found = 1'b1;
                end else begin
                    prev = at;
                    at   = at + 1 + 32'(hdr_size[at]);
                end
            end
            // unknown address or double free leaves the heap as it was
            if (found && !hdr_free[at]) begin
                hdr_free[at] = 1'b1;
                nx = at + 1 + 32'(hdr_size[at]);
                if (nx < HEAP_WORDS && hdr_free[nx])
                    hdr_size[at] = 8'(32'(hdr_size[at]) + 1 + 32'(hdr_size[nx]));
                if (prev != at && hdr_free[prev])
                    hdr_size[prev] = 8'(32'(hdr_size[prev]) + 1 + 32'(hdr_size[at]));
                rsp.status = STATUS_OK;
            end
        end
        return rsp;
    endfunction

    // Mostly back to back, some short gaps, a rare long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Request builders. The field the command ignores still gets random
    // content so every bit of it toggles.
    function automatic t_req alloc_req(input int unsigned bytes);
        t_req r;
        r.cmd           = CMD_ALLOC;
        r.alloc_bytes   = BYTES_W'(bytes);
        r.block_address = ADDR_W'($urandom_range(0, 127));
        return r;
    endfunction

    function automatic t_req free_req(input int unsigned addr);
        t_req r;
        r.cmd           = CMD_FREE;
        r.alloc_bytes   = BYTES_W'($urandom_range(0, 512));
        r.block_address = ADDR_W'(addr);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Send one request beat. start stays high across back-to-back beats;
    // it is only dropped when an idle gap follows. The beat is taken at
    // the first edge with start high and busy low, and the expectation is
    // queued at that same edge.
    // ---------------------------------------------------------------
    task automatic issue_request(input t_req r);
        int unsigned gap;
        int          hits[$];
        t_rsp        want;
        gap = pick_gap();
        if (gap > 0) begin
            if (start_held) begin
                start      <= 1'b0;
                start_held  = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_req      <= r;
        start_held  = 1'b1;
        do @(posedge i_clk); while (busy);
        want = heap_predict(r);
        rsp_expected_q.push_back(want);
        // track handed-out blocks so later frees are mostly well formed
        if (want.status == STATUS_OK) begin
            if (r.cmd == CMD_ALLOC) begin
                live_q.push_back(want.result_address);
            end else begin
                hits = live_q.find_first_index(x) with (x == r.block_address);
                if (hits.size() != 0) live_q.delete(hits[0]);
                freed_q.push_back(r.block_address);
                if (freed_q.size() > FREED_KEEP) void'(freed_q.pop_front());
            end
        end
    endtask

    // Hold the sender off until every outstanding beat has answered.
    task automatic drain_results();
        if (start_held) begin
            start      <= 1'b0;
            start_held  = 1'b0;
            @(posedge i_clk);
        end
        while (rsp_expected_q.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Result checker: every o_done beat is matched against the oldest
    // expectation, field by field.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (rsp_expected_q.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("unexpected result beat: addr=%0d status=%0d",
                             o_rsp.result_address, o_rsp.status);
                mismatch_cnt++;
                fail_cnt++;
            end else begin
                want = rsp_expected_q.pop_front();
                if (o_rsp.result_address !== want.result_address ||
                    o_rsp.status !== want.status) begin
                    if (mismatch_cnt < 10)
                        $display("mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                                 want.result_address, want.status,
                                 o_rsp.result_address, o_rsp.status);
                    mismatch_cnt++;
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: counts edges at which neither a request nor a result moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Directed tests
    // ---------------------------------------------------------------

    // Largest requests against a fresh heap: too big, one short of the
    // strict fit, then the biggest that fits; a zero-byte request against
    // the one-word remainder must not take it. Also double free and an
    // address that is no payload at all.
    task automatic test_size_limits();
        issue_request(alloc_req(512));
        issue_request(alloc_req(504));
        issue_request(alloc_req(500));
        issue_request(alloc_req(0));
        issue_request(free_req(127));   // remainder block is free already
        issue_request(free_req(1));     // merges with remainder, heap whole again
        issue_request(free_req(1));
        issue_request(free_req(0));
    endtask

    // Word rounding: 0, 1, 4 and 5 bytes give 0, 1, 1 and 2 words.
    task automatic test_split_rounding();
        issue_request(alloc_req(0));
        issue_request(alloc_req(1));
        issue_request(alloc_req(4));
        issue_request(alloc_req(5));
    endtask

    // Frees that merge forward and both ways, plus a free of a
    // header that a merge has swallowed (stale, so unknown).
    task automatic test_merge_both_sides();
        issue_request(free_req(2));
        issue_request(free_req(1));     // successor merge only
        issue_request(free_req(3));     // header now inside a merged block
        issue_request(free_req(6));     // merges with the big remainder
        issue_request(free_req(4));     // successor and predecessor merge
        issue_request(free_req(127));
    endtask

    // Blocks pushed to the top of the heap: the highest payload index and
    // a successor merge next to the heap end.
    task automatic test_tail_block();
        issue_request(alloc_req(496));
        issue_request(alloc_req(0));
        issue_request(alloc_req(0));    // only a one-word block left
        issue_request(free_req(126));
        issue_request(free_req(1));
    endtask

    // ---------------------------------------------------------------
    // Random traffic: mostly well formed alloc/free pairs on live blocks,
    // with double frees, random addresses and oversized requests mixed in.
    // Periodically everything live is returned so the heap coalesces.
    // ---------------------------------------------------------------
    task automatic test_random_traffic();
        int unsigned roll;
        int unsigned bytes;
        int unsigned idx;
        t_req        r;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            if (n % 200 == 199) drain_results();
            if (n % 250 == 249) begin
                while (live_q.size() != 0) begin
                    idx = $urandom_range(0, live_q.size() - 1);
                    issue_request(free_req(live_q[idx]));
                end
            end
            roll = $urandom_range(0, 99);
            if (roll < 45 || (roll < 85 && live_q.size() == 0)) begin
                roll = $urandom_range(0, 99);
                if (roll < 70)      bytes = $urandom_range(0, 32);
                else if (roll < 90) bytes = $urandom_range(33, 128);
                else if (roll < 98) bytes = $urandom_range(129, 512);
                else                bytes = ($urandom_range(0, 1) != 0) ? 512 : 0;
                r = alloc_req(bytes);
            end else if (roll < 85) begin
                idx = $urandom_range(0, live_q.size() - 1);
                r   = free_req(live_q[idx]);
            end else if (roll < 93 && freed_q.size() != 0) begin
                idx = $urandom_range(0, freed_q.size() - 1);
                r   = free_req(freed_q[idx]);
            end else begin
                r = free_req($urandom_range(0, 127));
            end
            issue_request(r);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < HEAP_WORDS; i++) begin
            hdr_size[i] = '0;
            hdr_free[i] = 1'b0;
        end
        hdr_free[0] = 1'b1;
        hdr_size[0] = 8'(HEAP_WORDS - 1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_size_limits();
        drain_results();
        test_split_rounding();
        test_merge_both_sides();
        drain_results();
        test_tail_block();
        drain_results();
        test_random_traffic();

        drain_results();
        // catch any stray result beat after the last one expected
        repeat (HEAP_WORDS + 8) @(posedge i_clk);
        if (rsp_expected_q.size() != 0) fail_cnt++;
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ first_fit_block_allocator.f @@
sv/ffba_pkg.sv
sv/ffba_hdr_mem.sv
sv/ffba_ctrl.sv
sv/first_fit_block_allocator.sv
sv/ffba_checker.sv
test/tb_first_fit_block_allocator.sv
